/* hdl/crcc_pkg.sv */
// ---------------------------------------------------------------------------
// crcc_pkg : shared types, constants and functions for the CRC32C combiner
// Holds the zero-byte operator powers as a constant table.
// ---------------------------------------------------------------------------
`default_nettype none

package crcc_pkg;

   localparam int CRC_W       = 32;
   localparam int LENGTH_BITS = 32;
   localparam logic [CRC_W-1:0] CRC32C_POLY = 32'h82F63B78;

   // length bits that can matter: the input field is 32 bits wide
   localparam int STEPS = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
   localparam int IDX_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   // column j is the image of input bit j
   typedef logic [CRC_W-1:0][CRC_W-1:0] matrix_type;
   typedef matrix_type [STEPS-1:0]      power_table_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   function automatic logic [CRC_W-1:0] gf2_apply(input matrix_type m,
                                                   input logic [CRC_W-1:0] v);
      logic [CRC_W-1:0] acc;
      acc = '0;
      for (int j = 0; j < CRC_W; j++) begin
         if (v[j]) begin
            acc = acc ^ m[j];
         end
      end
      return acc;
   endfunction

   // operator for one zero byte, then repeated squaring: entry i is M^(2^i)
   function automatic power_table_type build_powers();
      power_table_type  tbl;
      matrix_type       m;
      matrix_type       nxt;
      logic [CRC_W-1:0] v;
      for (int j = 0; j < CRC_W; j++) begin
         v = '0;
         v[j] = 1'b1;
         for (int b = 0; b < 8; b++) begin
            v = v[0] ? ((v >> 1) ^ CRC32C_POLY) : (v >> 1);
         end
         m[j] = v;
      end
      for (int i = 0; i < STEPS; i++) begin
         tbl[i] = m;
         for (int j = 0; j < CRC_W; j++) begin
            nxt[j] = gf2_apply(m, m[j]);
         end
         m = nxt;
      end
      return tbl;
   endfunction

   localparam power_table_type POWERS = build_powers();

endpackage

`default_nettype wire

/* hdl/crcc_if.sv */
// ---------------------------------------------------------------------------
// crcc_if : request and response channels of the CRC32C combiner
// Valid/ready channels; a beat moves when both are high at a clock edge.
// ---------------------------------------------------------------------------
`default_nettype none

interface crcc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] first_crc;
   logic [31:0] second_crc;
   logic [31:0] second_length;

   modport source (output valid, output first_crc, output second_crc,
                   output second_length, input ready);
   modport sink   (input valid, input first_crc, input second_crc,
                   input second_length, output ready);
endinterface

interface crcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] joined_crc;

   modport source (output valid, output joined_crc, input ready);
   modport sink   (input valid, input joined_crc, output ready);
endinterface

`default_nettype wire

/* hdl/crcc_matvec.sv */
// ---------------------------------------------------------------------------
// crcc_matvec : shared GF(2) matrix-vector unit
// Selects M^(2^step) from the constant table and applies it to a vector.
// ---------------------------------------------------------------------------
`default_nettype none

module crcc_matvec (
   input  wire logic [crcc_pkg::IDX_W-1:0] step,
   input  wire logic [crcc_pkg::CRC_W-1:0] vec,
   output logic      [crcc_pkg::CRC_W-1:0] product
);
   import crcc_pkg::*;

   matrix_type sel;

   always_comb begin
      sel     = POWERS[step];
      product = gf2_apply(sel, vec);
   end

endmodule

`default_nettype wire

/* hdl/crc32c_combine_engine_top.sv */
// ---------------------------------------------------------------------------
// crc32c_combine_engine_top : joins two CRC32C values into one
// Sequence: accept a request in idle, then one matrix-vector step per length
// bit up to the highest set one, then the result beat; zero length skips the
// steps. Busy until the result is taken; new requests only accepted in idle.
// Reset: synchronous, returns the sequencer to idle, no result pending.
// ---------------------------------------------------------------------------
`default_nettype none

module crc32c_combine_engine_top (
   input  wire logic   clock,
   input  wire logic   reset,
   crcc_req_if.sink    req,
   crcc_rsp_if.source  rsp
);
   import crcc_pkg::*;

   state_type          state_ff, state_in;
   logic [CRC_W-1:0]   vec_ff, vec_in;
   logic [CRC_W-1:0]   crc_b_ff, crc_b_in;
   logic [STEPS-1:0]   len_ff, len_in;
   logic [IDX_W-1:0]   step_ff, step_in;
   logic [CRC_W-1:0]   product;
   logic [STEPS-1:0]   req_len;
   logic               last_step;

   assign req_len   = req.second_length[STEPS-1:0];
   assign last_step = ((len_ff >> 1) == '0);

   crcc_matvec u_matvec (
      .step    (step_ff),
      .vec     (vec_ff),
      .product (product)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = (req_len == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      vec_in    = vec_ff;
      crc_b_in  = crc_b_ff;
      len_in    = len_ff;
      step_in   = step_ff;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            vec_in    = req.first_crc;
            // zero length passes the first CRC through untouched
            crc_b_in  = (req_len == '0) ? '0 : req.second_crc;
            len_in    = req_len;
            step_in   = '0;
         end
         ST_RUN: begin
            if (len_ff[0]) begin
               vec_in = product;
            end
            len_in  = len_ff >> 1;
            step_in = step_ff + 1'b1;
         end
         ST_DONE: begin
            rsp.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp.joined_crc = vec_ff ^ crc_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff   <= vec_in;
      crc_b_ff <= crc_b_in;
      len_ff   <= len_in;
      step_ff  <= step_in;
   end

endmodule

`default_nettype wire
